[rtl/gmdw_pkg.sv]
package gmdw_pkg;

    localparam int COORD_W   = 6;
    localparam int CELL_AW   = 2 * COORD_W;
    localparam int CELL_CNT  = 1 << CELL_AW;
    localparam int COUNT_W   = CELL_AW + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_STEP    = 2'd2;

    localparam logic [1:0] ST_LOOKING = 2'd0;
    localparam logic [1:0] ST_RETRACE = 2'd1;
    localparam logic [1:0] ST_STUCK   = 2'd2;
    localparam logic [1:0] ST_FREE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRACE = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               cell_open;
    } gmdw_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [1:0]         walk_status;
        logic               target_valid;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
    } gmdw_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RS_MARK,
        S_ST_TOP,
        S_ST_POP,
        S_ST_BACK,
        S_NB_ADDR,
        S_NB_TEST,
        S_DONE
    } gmdw_state_t;

endpackage

[rtl/grid_maze_dfs_walker_unit.sv]
// Depth-first maze walker over a 64 by 64 grid. An item is a command word:
// load one cell, restart the walk, or take one step. Start is taken when busy
// is low; the result word appears on result for exactly one cycle with
// result_valid high and the receiver cannot stall it. Busy stays high through
// the result cycle. A full step reads and pops the top of the look stack,
// then forms and tests each of the four neighbour addresses in turn, because
// the open and discovered maps and the stacks are single-port memories that
// are visited one neighbour at a time. A step that finds the look stack
// empty, steps back or reaches the exit ends sooner. A restart sweeps the
// discovered map one entry per cycle. After reset the open map is cleared by
// the same sweep before busy drops.
module grid_maze_dfs_walker_unit
    import gmdw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gmdw_in_t             cmd,
    output logic                 result_valid,
    output gmdw_out_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // Configuration registers.
    logic [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic               rt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            ex_reg <= '1;
            ey_reg <= '1;
            rt_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_X: sx_reg <= cfg_data[COORD_W-1:0];
                CFG_START_Y: sy_reg <= cfg_data[COORD_W-1:0];
                CFG_END_X:   ex_reg <= cfg_data[COORD_W-1:0];
                CFG_END_Y:   ey_reg <= cfg_data[COORD_W-1:0];
                CFG_RETRACE: rt_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Memories: open map, discovered map, look stack and retrace stack.
    logic                open_mem [CELL_CNT];
    logic                seen_mem [CELL_CNT];
    logic [CELL_AW-1:0]  look_mem [CELL_CNT];
    logic [CELL_AW-1:0]  back_mem [CELL_CNT];

    gmdw_state_t         state_reg, state_next;
    logic [CELL_AW-1:0]  sweep_reg, sweep_next;
    logic                boot_reg, boot_next;
    logic [COUNT_W-1:0]  lc_reg, lc_next, rc_reg, rc_next;
    logic [COORD_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [1:0]          st_reg, st_next;
    logic [CELL_AW-1:0]  top_reg, top_next;
    logic [2:0]          nb_reg, nb_next;
    logic [CELL_AW-1:0]  na_reg, na_next;
    logic                nv_reg, nv_next;

    // Memory request signals.
    logic                open_we, open_wd, seen_we, seen_wd;
    logic [CELL_AW-1:0]  open_a, seen_a, look_a, look_wd, back_a, back_wd;
    logic                look_we, back_we;
    logic                open_q, seen_q;
    logic [CELL_AW-1:0]  look_q, back_q;

    always_ff @(posedge clk)
    begin
        if (open_we) open_mem[open_a] <= open_wd;
        open_q <= open_mem[open_a];
        if (seen_we) seen_mem[seen_a] <= seen_wd;
        seen_q <= seen_mem[seen_a];
        if (look_we) look_mem[look_a] <= look_wd;
        look_q <= look_mem[look_a];
        if (back_we) back_mem[back_a] <= back_wd;
        back_q <= back_mem[back_a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            sweep_reg <= '0;
            boot_reg  <= 1'b1;
            lc_reg    <= '0;
            rc_reg    <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            st_reg    <= ST_LOOKING;
            nb_reg    <= '0;
            nv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            boot_reg  <= boot_next;
            lc_reg    <= lc_next;
            rc_reg    <= rc_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            st_reg    <= st_next;
            nb_reg    <= nb_next;
            nv_reg    <= nv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        na_reg  <= na_next;
    end

    logic [COORD_W-1:0]   tx, ty;
    logic signed [COORD_W:0] ddx, ddy;
    logic                 adjacent;

    assign tx = look_q[COORD_W-1:0];
    assign ty = look_q[CELL_AW-1:COORD_W];
    assign ddx = $signed({1'b0, cx_reg}) - $signed({1'b0, tx});
    assign ddy = $signed({1'b0, cy_reg}) - $signed({1'b0, ty});
    // Squared distance at most one: one axis equal, other off by at most one.
    assign adjacent = ((ddx == '0) && (ddy == '0 || ddy == 7'sd1 || ddy == -7'sd1)) ||
                      ((ddy == '0) && (ddx == 7'sd1 || ddx == -7'sd1));

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        boot_next  = boot_reg;
        lc_next    = lc_reg;
        rc_next    = rc_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        st_next    = st_reg;
        top_next   = top_reg;
        nb_next    = nb_reg;
        na_next    = na_reg;
        nv_next    = nv_reg;
        open_we = 1'b0; open_wd = 1'b0; open_a = na_reg;
        seen_we = 1'b0; seen_wd = 1'b0; seen_a = na_reg;
        look_we = 1'b0; look_wd = na_reg;
        look_a  = lc_reg[CELL_AW-1:0] - 1'b1;
        back_we = 1'b0; back_wd = top_reg;
        back_a  = rc_reg[CELL_AW-1:0] - 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                look_a = lc_reg[CELL_AW-1:0] - 1'b1;
                // The result cycle is spent in idle with busy still high.
                if (start && !busy)
                begin
                    unique case (cmd.op)
                        OP_LOAD:
                        begin
                            open_we = 1'b1;
                            open_a  = {cmd.cell_y, cmd.cell_x};
                            open_wd = cmd.cell_open;
                            state_next = S_DONE;
                        end
                        OP_RESTART:
                        begin
                            sweep_next = '0;
                            state_next = S_CLEAR;
                        end
                        OP_STEP: state_next = S_ST_TOP;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                // Sweep: after reset the open and seen maps, on restart the seen map.
                seen_we = 1'b1;
                seen_a  = sweep_reg;
                open_we = boot_reg;
                open_a  = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1)
                begin
                    if (boot_reg)
                    begin
                        boot_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_RS_MARK;
                end
            end
            S_RS_MARK:
            begin
                seen_we = 1'b1;
                seen_wd = 1'b1;
                seen_a  = {sy_reg, sx_reg};
                look_we = 1'b1;
                look_a  = '0;
                look_wd = {sy_reg, sx_reg};
                lc_next = COUNT_W'(1);
                rc_next = '0;
                cx_next = sx_reg;
                cy_next = sy_reg;
                st_next = ST_LOOKING;
                state_next = S_DONE;
            end
            S_ST_TOP:
            begin
                // look_q holds the top of the look stack now.
                if (lc_reg == '0)
                begin
                    st_next = ST_STUCK;
                    state_next = S_DONE;
                end
                else if (rt_reg && !adjacent)
                begin
                    st_next = ST_RETRACE;
                    if (rc_reg != '0)
                    begin
                        rc_next = rc_reg - 1'b1;
                        back_a  = rc_reg[CELL_AW-1:0] - 2'd2;
                        if (rc_reg > COUNT_W'(1))
                            state_next = S_ST_BACK;
                        else
                            state_next = S_DONE;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    if (rt_reg)
                        st_next = ST_LOOKING;
                    top_next = look_q;
                    lc_next  = lc_reg - 1'b1;
                    state_next = S_ST_POP;
                end
            end
            S_ST_BACK:
            begin
                cx_next = back_q[COORD_W-1:0];
                cy_next = back_q[CELL_AW-1:COORD_W];
                state_next = S_DONE;
            end
            S_ST_POP:
            begin
                if (rc_reg != COUNT_W'(CELL_CNT))
                begin
                    back_we = 1'b1;
                    back_a  = rc_reg[CELL_AW-1:0];
                    rc_next = rc_reg + 1'b1;
                end
                cx_next = top_reg[COORD_W-1:0];
                cy_next = top_reg[CELL_AW-1:COORD_W];
                nb_next = '0;
                if (top_reg == {ey_reg, ex_reg})
                begin
                    st_next = ST_FREE;
                    state_next = S_DONE;
                end
                else
                    state_next = S_NB_ADDR;
            end
            S_NB_ADDR:
            begin
                // Form the neighbour address and start the map reads.
                nv_next = 1'b1;
                na_next = top_reg;
                unique case (nb_reg[1:0])
                    2'd0:
                    begin
                        nv_next = top_reg[COORD_W-1:0] != '0;
                        na_next[COORD_W-1:0] = top_reg[COORD_W-1:0] - 1'b1;
                    end
                    2'd1:
                    begin
                        nv_next = top_reg[COORD_W-1:0] != '1;
                        na_next[COORD_W-1:0] = top_reg[COORD_W-1:0] + 1'b1;
                    end
                    2'd2:
                    begin
                        nv_next = top_reg[CELL_AW-1:COORD_W] != '0;
                        na_next[CELL_AW-1:COORD_W] = top_reg[CELL_AW-1:COORD_W] - 1'b1;
                    end
                    default:
                    begin
                        nv_next = top_reg[CELL_AW-1:COORD_W] != '1;
                        na_next[CELL_AW-1:COORD_W] = top_reg[CELL_AW-1:COORD_W] + 1'b1;
                    end
                endcase
                open_a = na_next;
                seen_a = na_next;
                state_next = S_NB_TEST;
            end
            S_NB_TEST:
            begin
                if (nv_reg && open_q && !seen_q)
                begin
                    seen_we = 1'b1;
                    seen_wd = 1'b1;
                    if (lc_reg != COUNT_W'(CELL_CNT))
                    begin
                        look_we = 1'b1;
                        look_a  = lc_reg[CELL_AW-1:0];
                        lc_next = lc_reg + 1'b1;
                    end
                end
                nb_next = nb_reg + 1'b1;
                if (nb_reg == 3'd3)
                    state_next = S_DONE;
                else
                    state_next = S_NB_ADDR;
            end
            S_DONE:
            begin
                // Present the new top of the look stack on the read port.
                look_a = lc_reg[CELL_AW-1:0] - 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic res_v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_v_reg <= 1'b0;
        else
            res_v_reg <= (state_reg == S_DONE);
    end

    assign busy         = (state_reg != S_IDLE) || res_v_reg;
    assign result_valid = res_v_reg;

    // look_q was read in S_DONE, so it is the current top in the result cycle.
    always_comb
    begin
        result.pos_x        = cx_reg;
        result.pos_y        = cy_reg;
        result.walk_status  = st_reg;
        result.target_valid = lc_reg != '0;
        result.target_x     = (lc_reg != '0) ? look_q[COORD_W-1:0] : '0;
        result.target_y     = (lc_reg != '0) ? look_q[CELL_AW-1:COORD_W] : '0;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        lc_reg <= COUNT_W'(CELL_CNT) && rc_reg <= COUNT_W'(CELL_CNT))
        else $error("stack count beyond depth");
    a_res_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result held for two cycles");
    a_busy_res: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("idle while result shown");
`endif

endmodule
